// ===== rtl/fcd_pkg.sv =====
// Shared constants and types for the feedback comb delay block.
// Used by fcd_feedback and feedback_comb_delay; no dependencies.
package fcd_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DELAY_LEN_W = 13;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 15;
  localparam int RND_BIAS    = 1 << (GAIN_FRAC - 1);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DELAY_LENGTH  = 2'd0;
  localparam cfg_idx_t REG_FEEDBACK_GAIN = 2'd1;

  localparam logic [DELAY_LEN_W-1:0] DELAY_LEN_RST = 13'd1;
  localparam logic [GAIN_W-1:0]      GAIN_RST      = 16'h4000;

endpackage

// ===== rtl/fcd_delay_mem.sv =====
// Delay line storage: one write port, one read port with registered data.
// No package dependencies.
module fcd_delay_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 24,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd_data,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fcd_feedback.sv =====
// Feedback arithmetic: gain times delayed sample, round, add input, saturate.
// Depends on fcd_pkg for gain format constants.
module fcd_feedback #(
  parameter int SW = 24
) (
  input  logic signed [fcd_pkg::GAIN_W-1:0] gain,
  input  logic signed [SW-1:0]              dly,
  input  logic signed [SW-1:0]              x,
  output logic signed [SW-1:0]              y,
  output logic                              clip
);
  import fcd_pkg::*;

  localparam int PW = SW + GAIN_W;
  localparam int FW = PW - GAIN_FRAC + 1;
  localparam int XE = GAIN_W - GAIN_FRAC + 2;

  logic signed [PW-1:0] prod;
  logic signed [PW:0]   rnd;
  logic signed [FW-1:0] fb;
  logic signed [FW:0]   sum;
  logic [FW-SW+1:0]     upper;

  assign prod  = gain * dly;
  assign rnd   = {prod[PW-1], prod} + (PW+1)'(RND_BIAS);
  assign fb    = rnd[PW:GAIN_FRAC];
  assign sum   = {fb[FW-1], fb} + {{XE{x[SW-1]}}, x};
  assign upper = sum[FW:SW-1];
  assign clip  = !((&upper) || !(|upper));

  always_comb begin
    if (!clip) begin
      y = sum[SW-1:0];
    end else if (sum[FW]) begin
      y = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y = {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/feedback_comb_delay.sv =====
// Feedback comb filter top level: control pipeline, registers, clear sweep.
// Depends on fcd_pkg, fcd_delay_mem and fcd_feedback.
//
// Usage:
//   Input channel in_valid/in_stall carries one signed sample and an
//   end-of-block mark; output channel out_valid/out_stall returns
//   y = sat(x + round(g * y[n-D])), a saturation flag and the mark.
//   Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
//   delay_length (index 0) and feedback_gain (index 1); cfg_ready is
//   always high. Write configuration only while no transaction is in flight.
//   Pipeline: an accepted sample and its delayed-sample read are registered
//   in the compute stage; the result is then loaded into the output register.
//   Throughput: one sample per cycle while the receiver does not stall, set
//   by the single read and single write port of the delay memory; a delay of
//   one sample is served by forwarding the last result.
//   Reset: the delay memory is swept to zero, one entry per cycle, over all
//   MAX_DELAY entries; in_stall is high during the sweep.
//   Receiver stall: the output register holds, the compute stage holds
//   its transaction, and in_stall is high while that transaction waits.
module feedback_comb_delay #(
  parameter int MAX_DELAY    = 4096,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample,
  input  logic                             in_block_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   out_sample,
  output logic                             out_clipped,
  output logic                             out_block_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  fcd_pkg::cfg_idx_t                cfg_index,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fcd_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = $clog2(MAX_DELAY);
  localparam int DW = $clog2(MAX_DELAY + 1);
  localparam int CW = (DW > DELAY_LEN_W) ? DW : DELAY_LEN_W;

  logic [DELAY_LEN_W-1:0] delay_len_r;
  logic signed [GAIN_W-1:0] gain_r;

  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_nxt;

  logic                 s1_v_r;
  logic signed [SW-1:0] s1_x_r;
  logic                 s1_last_r;
  logic [AW-1:0]        s1_wa_r;
  logic                 s1_fwd_r;
  logic                 s1_fwd_nxt;
  logic signed [SW-1:0] last_y_r;

  logic                 out_v_r;
  logic signed [SW-1:0] out_sample_r;
  logic                 out_clip_r;
  logic                 out_last_r;

  logic                 out_free;
  logic                 s1_adv;
  logic                 in_acc;
  logic [DW-1:0]        d_eff;
  logic [DW-1:0]        wp_ext;
  logic [DW:0]          rd_full;
  logic [AW-1:0]        rd_addr;
  logic [SW-1:0]        mem_rd_data;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [SW-1:0]        mem_wd;
  logic signed [SW-1:0] dly;
  logic signed [SW-1:0] y;
  logic                 clip;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_v_r || !out_stall;
  assign s1_adv    = s1_v_r && out_free;
  assign in_stall  = clr_active_r || (s1_v_r && !out_free);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    if (delay_len_r == '0) begin
      d_eff = DW'(1);
    end else if (CW'(delay_len_r) > CW'(MAX_DELAY)) begin
      d_eff = DW'(MAX_DELAY);
    end else begin
      d_eff = DW'(delay_len_r);
    end
  end

  assign wp_ext = DW'(wp_r);

  always_comb begin
    if (wp_ext >= d_eff) begin
      rd_full = {1'b0, wp_ext} - {1'b0, d_eff};
    end else begin
      rd_full = {1'b0, wp_ext} + (DW+1)'(MAX_DELAY) - {1'b0, d_eff};
    end
  end

  assign rd_addr    = rd_full[AW-1:0];
  assign wp_nxt     = (wp_r == AW'(MAX_DELAY - 1)) ? '0 : wp_r + 1'b1;
  assign s1_fwd_nxt = s1_adv && (rd_addr == s1_wa_r);

  assign mem_we = clr_active_r || s1_adv;
  assign mem_wa = clr_active_r ? clr_addr_r : s1_wa_r;
  assign mem_wd = clr_active_r ? '0 : y;

  fcd_delay_mem #(
    .DEPTH (MAX_DELAY),
    .WIDTH (SW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .re      (in_acc),
    .ra      (rd_addr),
    .rd_data (mem_rd_data),
    .we      (mem_we),
    .wa      (mem_wa),
    .wd      (mem_wd)
  );

  assign dly = s1_fwd_r ? last_y_r : $signed(mem_rd_data);

  fcd_feedback #(
    .SW (SW)
  ) u_fb (
    .gain (gain_r),
    .dly  (dly),
    .x    (s1_x_r),
    .y    (y),
    .clip (clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_len_r <= DELAY_LEN_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELAY_LENGTH:  delay_len_r <= cfg_data[DELAY_LEN_W-1:0];
        REG_FEEDBACK_GAIN: gain_r      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(MAX_DELAY - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        wp_r   <= wp_nxt;
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r    <= in_sample;
      s1_last_r <= in_block_last;
      s1_wa_r   <= wp_r;
      s1_fwd_r  <= s1_fwd_nxt;
    end
    if (s1_adv) begin
      last_y_r <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= y;
      out_clip_r   <= clip;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_sample     = out_sample_r;
  assign out_clipped    = out_clip_r;
  assign out_block_last = out_last_r;

endmodule
